### rtl/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types, constants and the compress network step for the bit
// deposit / extract pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bde_pkg;

  // Data width on the ports (fixed) and active operand width (8..64).
  localparam int DW     = 64;
  localparam int WIDTH  = 64;
  localparam int IW     = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int GW     = 8;
  localparam int NGRP   = (WIDTH + GW - 1) / GW;
  localparam int LW     = $clog2(GW);
  localparam int CW     = $clog2(GW + 1);
  localparam int LSPLIT = (IW + 1) / 2;

  // Input word: mask_word, source_word, zero pad to bytes.
  localparam int IN_BITS = 2 * DW;
  localparam int IN_TW   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TW  = ((DW + 7) / 8) * 8;

  typedef enum logic {
    OP_DEPOSIT = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  // Front end to back end: free positions and their exclusive prefix counts.
  typedef struct packed {
    op_t                      op;
    logic [WIDTH-1:0]         free;
    logic [WIDTH-1:0]         src;
    logic [WIDTH-1:0][IW-1:0] prefix;
  } pfx_word_t;

  // Compress network state: one bit, a valid and a shift distance per lane.
  typedef struct packed {
    logic [WIDTH-1:0]         dat;
    logic [WIDTH-1:0]         vld;
    logic [WIDTH-1:0][IW-1:0] tag;
  } cmp_t;

  // Levels lo..hi-1 of the compress network. Each lane moves down by 2^j
  // when bit j of its distance is set; LSB-first order never collides.
  function automatic cmp_t cmp_levels(cmp_t a, int lo, int hi);
    cmp_t cur;
    cmp_t nxt;
    int   s;
    cur = a;
    for (int j = lo; j < hi; j++) begin
      nxt = '0;
      s   = 1 << j;
      for (int q = 0; q < WIDTH; q++) begin
        if (cur.vld[q] && !cur.tag[q][j]) begin
          nxt.dat[q] = cur.dat[q];
          nxt.vld[q] = 1'b1;
          nxt.tag[q] = cur.tag[q];
        end
        if (q + s < WIDTH) begin
          if (cur.vld[q+s] && cur.tag[q+s][j]) begin
            nxt.dat[q] = cur.dat[q+s];
            nxt.vld[q] = 1'b1;
            nxt.tag[q] = cur.tag[q+s];
          end
        end
      end
      cur = nxt;
    end
    return cur;
  endfunction

endpackage

### rtl/bde_front.sv
// ----------------------------------------------------------------------------
// bde_front
// Two pipeline stages: free-position map with per-group counts, then the
// exclusive prefix count of free positions for every bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bde_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bde_pkg::op_t           in_op,
  input  logic [bde_pkg::DW-1:0] in_mask,
  input  logic [bde_pkg::DW-1:0] in_src,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bde_pkg::pfx_word_t     out_word
);

  // stage 1
  logic                                              v1;
  bde_pkg::op_t                                      op1;
  logic [bde_pkg::WIDTH-1:0]                         free1;
  logic [bde_pkg::WIDTH-1:0]                         src1;
  logic [bde_pkg::WIDTH-1:0][bde_pkg::LW-1:0]        loc1;
  logic [bde_pkg::NGRP-1:0][bde_pkg::CW-1:0]         gcnt1;
  logic [bde_pkg::WIDTH-1:0]                         free_next;
  logic [bde_pkg::WIDTH-1:0][bde_pkg::LW-1:0]        loc_next;
  logic [bde_pkg::NGRP-1:0][bde_pkg::CW-1:0]         gcnt_next;

  // stage 2
  logic                                              v2;
  bde_pkg::pfx_word_t                                word2;
  logic [bde_pkg::WIDTH-1:0][bde_pkg::IW-1:0]        prefix_next;
  logic [bde_pkg::NGRP-1:0][bde_pkg::IW:0]           base;

  logic rdy1;
  logic rdy2;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign free_next = ~in_mask[bde_pkg::WIDTH-1:0];

  always_comb begin
    loc_next  = '0;
    gcnt_next = '0;
    for (int p = 0; p < bde_pkg::WIDTH; p++) begin
      for (int i = (p / bde_pkg::GW) * bde_pkg::GW; i < p; i++) begin
        loc_next[p] = loc_next[p] + bde_pkg::LW'(free_next[i]);
      end
    end
    for (int g = 0; g < bde_pkg::NGRP; g++) begin
      for (int i = g * bde_pkg::GW; i < (g + 1) * bde_pkg::GW; i++) begin
        if (i < bde_pkg::WIDTH) begin
          gcnt_next[g] = gcnt_next[g] + bde_pkg::CW'(free_next[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      op1   <= in_op;
      free1 <= free_next;
      src1  <= in_src[bde_pkg::WIDTH-1:0];
      loc1  <= loc_next;
      gcnt1 <= gcnt_next;
    end
  end

  always_comb begin
    base    = '0;
    for (int g = 1; g < bde_pkg::NGRP; g++) begin
      base[g] = base[g-1] + (bde_pkg::IW+1)'(gcnt1[g-1]);
    end
    for (int p = 0; p < bde_pkg::WIDTH; p++) begin
      prefix_next[p] = bde_pkg::IW'(base[p / bde_pkg::GW] + (bde_pkg::IW+1)'(loc1[p]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      word2.op     <= op1;
      word2.free   <= free1;
      word2.src    <= src1;
      word2.prefix <= prefix_next;
    end
  end

  assign out_valid = v2;
  assign out_word  = word2;

endmodule

### rtl/bit_deposit_extract_inverted_mask.sv
// ----------------------------------------------------------------------------
// bit_deposit_extract_inverted_mask
// Pipelined scatter/gather on the zero bits of a mask: deposit (PDEP with
// the complemented mask) and extract (PEXT with the complemented mask).
//
//   port group   dir  word contents (low bit first)
//   s_tuser      in   req_type[0]
//   s_tdata      in   mask_word[63:0], source_word[127:64]
//   m_tdata      out  result_word[63:0]
//
// One word per cycle sustained while m_tready stays high.
// Stages: free map and group counts, prefix counts, deposit select and
// lower compress levels, upper compress levels into the output register.
// Reset clears only the stage valid bits. Each stage advances when it is
// empty or the next one advances, so a stall loses and repeats nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_deposit_extract_inverted_mask (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // mask_word, source_word
  input  logic [bde_pkg::IN_TW-1:0]  s_tdata,
  // req_type
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // result_word
  output logic [bde_pkg::OUT_TW-1:0] m_tdata
);

  logic               fv;
  bde_pkg::pfx_word_t fword;

  logic                      v3;
  bde_pkg::op_t              op3;
  logic [bde_pkg::WIDTH-1:0] dep3;
  bde_pkg::cmp_t             cmp3;
  logic [bde_pkg::WIDTH-1:0] dep_next;
  bde_pkg::cmp_t             cmp_in;
  bde_pkg::cmp_t             cmp_next;
  bde_pkg::cmp_t             cmp_done;

  logic                      v4;
  logic [bde_pkg::WIDTH-1:0] res4;

  logic rdy3;
  logic rdy4;

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;

  bde_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (bde_pkg::op_t'(s_tuser)),
    .in_mask   (s_tdata[bde_pkg::DW-1:0]),
    .in_src    (s_tdata[2*bde_pkg::DW-1:bde_pkg::DW]),
    .out_valid (fv),
    .out_ready (rdy3),
    .out_word  (fword)
  );

  // deposit: free bit p takes source bit number prefix[p]
  // extract: free bit p moves down by the count of occupied bits below it
  always_comb begin
    for (int p = 0; p < bde_pkg::WIDTH; p++) begin
      dep_next[p]   = fword.free[p] & fword.src[fword.prefix[p]];
      cmp_in.dat[p] = fword.free[p] & fword.src[p];
      cmp_in.vld[p] = fword.free[p];
      cmp_in.tag[p] = bde_pkg::IW'(p) - fword.prefix[p];
    end
    cmp_next = bde_pkg::cmp_levels(cmp_in, 0, bde_pkg::LSPLIT);
    cmp_done = bde_pkg::cmp_levels(cmp3, bde_pkg::LSPLIT, bde_pkg::IW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= fv;
    end
    if (rdy3) begin
      op3  <= fword.op;
      dep3 <= dep_next;
      cmp3 <= cmp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4) begin
      res4 <= (op3 == bde_pkg::OP_EXTRACT) ? cmp_done.dat : dep3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = bde_pkg::OUT_TW'(res4);

endmodule

### sim/bit_deposit_extract_inverted_mask_tb.sv
// ----------------------------------------------------------------------------
// bit_deposit_extract_inverted_mask_tb
// Self-checking bench for the inverted-mask deposit/extract unit. Requests
// are predicted as they are accepted and the results are compared in order.
// Directed corner words come first, then random deposit and extract words
// with sparse, dense and uniform masks. Both stream sides idle and stall in
// random bursts, except in a calm tail at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_deposit_extract_inverted_mask_tb;

  localparam int RANDOM_WORDS = 1300;
  localparam int CALM_TAIL    = 150;

  class scatter_gather_model;
    logic [bde_pkg::DW-1:0] expected_words[$];
    int                     errors;

    function new();
      errors = 0;
    endfunction

    function logic [bde_pkg::DW-1:0] scatter_gather(bde_pkg::op_t op,
                                                    logic [bde_pkg::DW-1:0] mask,
                                                    logic [bde_pkg::DW-1:0] src);
      logic [bde_pkg::DW-1:0] r;
      int                     k;
      r = '0;
      k = 0;
      for (int p = 0; p < bde_pkg::WIDTH; p++) begin
        if (!mask[p]) begin
          if (op == bde_pkg::OP_DEPOSIT) r[p] = src[k];
          else                           r[k] = src[p];
          k++;
        end
      end
      return r;
    endfunction

    function void note_request(bde_pkg::op_t op, logic [bde_pkg::IN_TW-1:0] word);
      expected_words.push_back(scatter_gather(op, word[bde_pkg::DW-1:0],
                                              word[2*bde_pkg::DW-1:bde_pkg::DW]));
    endfunction

    function void check_result(logic [bde_pkg::OUT_TW-1:0] word);
      logic [bde_pkg::DW-1:0] want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (word[bde_pkg::DW-1:0] !== want) begin
        $display("%0t: result_word mismatch, expected %h, actual %h",
                 $time, want, word[bde_pkg::DW-1:0]);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [bde_pkg::IN_TW-1:0]  s_tdata;
  logic                       s_tuser;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [bde_pkg::OUT_TW-1:0] m_tdata;

  scatter_gather_model sg;
  bit                  calm;

  bit_deposit_extract_inverted_mask dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("bit_deposit_extract_inverted_mask_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sg.note_request(bde_pkg::op_t'(s_tuser), s_tdata);
    if (!rst && m_tvalid && m_tready) sg.check_result(m_tdata);
  end

  // result side backpressure
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [bde_pkg::DW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Called right after a falling edge; returns after the word is accepted.
  task automatic send_request(bde_pkg::op_t op, logic [bde_pkg::DW-1:0] mask,
                              logic [bde_pkg::DW-1:0] src);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {src, mask};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    logic [bde_pkg::DW-1:0] mask;
    logic [bde_pkg::DW-1:0] src;
    bde_pkg::op_t           op;

    sg       = new();
    calm     = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 2; i++) begin
      op = (i == 0) ? bde_pkg::OP_DEPOSIT : bde_pkg::OP_EXTRACT;
      send_request(op, '0, '1);
      send_request(op, '0, 64'h0123_4567_89ab_cdef);
      send_request(op, '1, '1);
      send_request(op, 64'h5555_5555_5555_5555, '1);
      send_request(op, 64'haaaa_aaaa_aaaa_aaaa, 64'hdead_beef_cafe_f00d);
      send_request(op, 64'hffff_ffff_ffff_fffe, '1);
      send_request(op, 64'h7fff_ffff_ffff_ffff, '1);
      send_request(op, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
      send_request(op, 64'hffff_ffff_0000_0000, 64'hffff_0000_ffff_0000);
      send_request(op, 64'h0000_0000_ffff_ffff, 64'h0000_ffff_0000_ffff);
      send_request(op, '0, '0);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_TAIL) calm = 1'b1;
      op = ($urandom_range(0, 1) != 0) ? bde_pkg::OP_EXTRACT : bde_pkg::OP_DEPOSIT;
      case ($urandom_range(0, 3))
        0:       mask = rand64() & rand64() & rand64();
        1:       mask = rand64() | rand64() | rand64();
        2:       mask = ~(64'h1 << $urandom_range(0, 63));
        default: mask = rand64();
      endcase
      src = ($urandom_range(0, 7) == 0) ? '1 : rand64();
      send_request(op, mask, src);
    end
    s_tvalid <= 1'b0;

    while (sg.expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sg.errors == 0 && sg.expected_words.size() == 0) begin
      $display("bit_deposit_extract_inverted_mask_tb: clean");
    end else begin
      $display("bit_deposit_extract_inverted_mask_tb: errors");
    end
    $finish;
  end

endmodule
